>>> hdl/swmm_pkg.sv
`timescale 1ns / 1ps

package swmm_pkg;

    localparam int SAMPLE_W      = 20;
    localparam int COUNT_W       = 7;
    localparam int DEFAULT_DEPTH = 64;

    typedef enum logic [2:0] {
        S_IDLE,
        S_UPDATE,
        S_SCAN,
        S_DIV,
        S_FINISH
    } t_state;

endpackage

>>> hdl/swmm_ram.sv
`timescale 1ns / 1ps

module swmm_ram #(
    parameter int WIDTH = 20,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> hdl/sliding_window_min_max_mean.sv
`timescale 1ns / 1ps
// Per accepted word: ring update, a scan of the 1..WINDOW_DEPTH held samples (one RAM
// read port, one entry a cycle), then a one-bit-a-cycle restoring divide over the
// running-sum width (20 + count width, 27 at depth 64). A new word is taken only in
// idle, once the last result is in the output register; a stalled result holds this off.
// Reset (synchronous, active low) empties the window and clears the running sum;
// the ring itself is not cleared, only data from held slots is ever used.

module sliding_window_min_max_mean
#(
    parameter int WINDOW_DEPTH = swmm_pkg::DEFAULT_DEPTH
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [swmm_pkg::SAMPLE_W-1:0] i_sample_us,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [swmm_pkg::SAMPLE_W-1:0] o_window_min_us,
    output logic [swmm_pkg::SAMPLE_W-1:0] o_window_max_us,
    output logic [swmm_pkg::SAMPLE_W-1:0] o_window_mean_us,
    output logic [swmm_pkg::COUNT_W-1:0]  o_held_count
);

    import swmm_pkg::*;

    localparam int AW  = $clog2(WINDOW_DEPTH);
    localparam int CW  = $clog2(WINDOW_DEPTH + 1);
    localparam int SW  = SAMPLE_W + CW;
    localparam int DCW = $clog2(SW + 1);

    localparam logic [CW-1:0]       DEPTH_C   = CW'(WINDOW_DEPTH);
    localparam logic [AW-1:0]       LAST_SLOT = AW'(WINDOW_DEPTH - 1);
    localparam logic [DCW-1:0]      DIV_LAST  = DCW'(SW - 1);
    localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = '1;

    t_state r_state, n_state;

    logic [AW-1:0]       r_wslot, n_wslot;
    logic [CW-1:0]       r_fill, n_fill;
    logic [SW-1:0]       r_sum, n_sum;
    logic [SAMPLE_W-1:0] r_sample, n_sample;
    logic [CW-1:0]       r_idx, n_idx;
    logic                r_pend, n_pend;
    logic [SAMPLE_W-1:0] r_min, n_min;
    logic [SAMPLE_W-1:0] r_max, n_max;
    logic [SW-1:0]       r_quo, n_quo;
    logic [CW-1:0]       r_rem, n_rem;
    logic [DCW-1:0]      r_dcnt, n_dcnt;
    logic                r_o_valid, n_o_valid;
    logic [SAMPLE_W-1:0] r_o_min, n_o_min;
    logic [SAMPLE_W-1:0] r_o_max, n_o_max;
    logic [SAMPLE_W-1:0] r_o_mean, n_o_mean;
    logic [COUNT_W-1:0]  r_o_count, n_o_count;

    logic                ram_we;
    logic [AW-1:0]       ram_raddr;
    logic [SAMPLE_W-1:0] ram_rdata;
    logic                accept;
    logic                full;
    logic                scan_done;
    logic                out_free;
    logic [CW:0]         trial;
    logic                trial_ge;

    swmm_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (WINDOW_DEPTH)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_wslot),
        .i_wdata (r_sample),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign accept    = i_valid && (r_state == S_IDLE);
    assign full      = (r_fill == DEPTH_C);
    assign scan_done = (r_idx >= r_fill) && r_pend;
    assign out_free  = !r_o_valid || i_ready;
    assign trial     = {r_rem, r_quo[SW-1]};
    assign trial_ge  = (trial >= {1'b0, r_fill});

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_state = S_UPDATE;
                end
            end
            S_UPDATE: n_state = S_SCAN;
            S_SCAN: begin
                if (scan_done) begin
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (r_dcnt == DIV_LAST) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control outputs: in idle the read port fetches the slot about to be overwritten
    always_comb begin
        o_ready   = 1'b0;
        ram_we    = 1'b0;
        ram_raddr = r_wslot;
        unique case (r_state)
            S_IDLE:   o_ready = 1'b1;
            S_UPDATE: ram_we = 1'b1;
            S_SCAN:   ram_raddr = r_idx[AW-1:0];
            S_DIV:    ;
            S_FINISH: ;
            default:  ;
        endcase
    end

    // datapath
    always_comb begin
        n_wslot   = r_wslot;
        n_fill    = r_fill;
        n_sum     = r_sum;
        n_sample  = r_sample;
        n_idx     = r_idx;
        n_pend    = r_pend;
        n_min     = r_min;
        n_max     = r_max;
        n_quo     = r_quo;
        n_rem     = r_rem;
        n_dcnt    = r_dcnt;
        n_o_valid = r_o_valid;
        n_o_min   = r_o_min;
        n_o_max   = r_o_max;
        n_o_mean  = r_o_mean;
        n_o_count = r_o_count;

        if (r_o_valid && i_ready) begin
            n_o_valid = 1'b0;
        end

        if (accept) begin
            n_sample = i_sample_us;
        end

        unique case (r_state)
            S_IDLE: ;
            S_UPDATE: begin
                // drop the oldest word once the window is full
                if (full) begin
                    n_sum = r_sum - SW'(ram_rdata) + SW'(r_sample);
                end else begin
                    n_sum  = r_sum + SW'(r_sample);
                    n_fill = r_fill + 1'b1;
                end
                n_wslot = (r_wslot == LAST_SLOT) ? '0 : r_wslot + 1'b1;
                n_idx   = '0;
                n_pend  = 1'b0;
                n_min   = SAMPLE_MAX;
                n_max   = '0;
            end
            S_SCAN: begin
                if (r_pend) begin
                    if (ram_rdata < r_min) n_min = ram_rdata;
                    if (ram_rdata > r_max) n_max = ram_rdata;
                end
                n_pend = (r_idx < r_fill);
                if (r_idx < r_fill) begin
                    n_idx = r_idx + 1'b1;
                end
                if (scan_done) begin
                    n_quo  = r_sum;
                    n_rem  = '0;
                    n_dcnt = '0;
                end
            end
            S_DIV: begin
                // restoring divide, one quotient bit a cycle
                if (trial_ge) begin
                    n_rem = CW'(trial - {1'b0, r_fill});
                end else begin
                    n_rem = CW'(trial);
                end
                n_quo  = {r_quo[SW-2:0], trial_ge};
                n_dcnt = r_dcnt + 1'b1;
            end
            S_FINISH: begin
                if (out_free) begin
                    n_o_valid = 1'b1;
                    n_o_min   = r_min;
                    n_o_max   = r_max;
                    n_o_mean  = SAMPLE_W'(r_quo);
                    n_o_count = COUNT_W'(r_fill);
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_wslot   <= '0;
            r_fill    <= '0;
            r_sum     <= '0;
            r_pend    <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_wslot   <= n_wslot;
            r_fill    <= n_fill;
            r_sum     <= n_sum;
            r_pend    <= n_pend;
            r_o_valid <= n_o_valid;
        end
        r_sample  <= n_sample;
        r_idx     <= n_idx;
        r_min     <= n_min;
        r_max     <= n_max;
        r_quo     <= n_quo;
        r_rem     <= n_rem;
        r_dcnt    <= n_dcnt;
        r_o_min   <= n_o_min;
        r_o_max   <= n_o_max;
        r_o_mean  <= n_o_mean;
        r_o_count <= n_o_count;
    end

    assign o_valid          = r_o_valid;
    assign o_window_min_us  = r_o_min;
    assign o_window_max_us  = r_o_max;
    assign o_window_mean_us = r_o_mean;
    assign o_held_count     = r_o_count;

endmodule
